// ===== design/assert_macros.svh =====
// assertion macros used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define FPC_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define FPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define FPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fpc_pkg.sv =====
// types and constants of the floating point precision converter
package fpc_pkg;

	typedef logic [1:0] action_t;

	localparam action_t ACT_F32_TO_BF16 = 2'd0;
	localparam action_t ACT_F32_TO_FP16 = 2'd1;
	localparam action_t ACT_BF16_TO_F32 = 2'd2;
	localparam action_t ACT_FP16_TO_F32 = 2'd3;

	localparam logic [15:0] F16_QNAN = 16'h7E00;
	localparam logic [15:0] F16_INF  = 16'h7C00;
	localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
	localparam logic [31:0] F32_INF  = 32'h7F80_0000;

	// fp32 biased exponent limits of the fp16 normal range
	localparam logic [7:0] F32_EXP_FP16_MAX = 8'd142;
	localparam logic [7:0] F32_EXP_FP16_MIN = 8'd113;
	localparam logic [7:0] F32_EXP_ALL_ONES = 8'hFF;

	// bias difference between fp32 and fp16
	localparam logic [7:0] EXP_BIAS_DIFF = 8'd112;

endpackage

// ===== design/fpc_convert.sv =====
// combinational conversion datapath for one word
module fpc_convert (
	input  fpc_pkg::action_t action,
	input  logic [31:0]      value_in,
	output logic [31:0]      value_out
);
	import fpc_pkg::*;

	logic [15:0] bf16_res;
	logic [15:0] fp16_res;
	logic [31:0] wide_res;

	// fp32 to bf16, round to nearest even, wraps at 16 bits
	always_comb begin
		logic inc_bf;
		inc_bf = value_in[15] & ((|value_in[14:0]) | value_in[16]);
		bf16_res = value_in[31:16] + {15'd0, inc_bf};
	end

	// fp32 to fp16
	always_comb begin
		logic        sgn;
		logic [7:0]  ex;
		logic [22:0] fr;
		logic [7:0]  exf8;
		logic [14:0] mag;
		logic        inc_fp;
		sgn    = value_in[31];
		ex     = value_in[30:23];
		fr     = value_in[22:0];
		exf8   = ex - EXP_BIAS_DIFF;
		inc_fp = fr[12] & ((|fr[11:0]) | fr[13]);
		// a mantissa carry walks into the exponent, reaching inf at the top
		mag    = {exf8[4:0], fr[22:13]} + {14'd0, inc_fp};
		if (ex == F32_EXP_ALL_ONES) begin
			fp16_res = {sgn, 15'd0} | ((|fr) ? F16_QNAN : F16_INF);
		end else if (ex > F32_EXP_FP16_MAX) begin
			fp16_res = {sgn, 15'd0} | F16_INF;
		end else if (ex < F32_EXP_FP16_MIN) begin
			fp16_res = {sgn, 15'd0};
		end else begin
			fp16_res = {sgn, mag};
		end
	end

	// fp16 to fp32
	always_comb begin
		logic        sgn;
		logic [4:0]  ex;
		logic [9:0]  m;
		logic [3:0]  p;
		logic [9:0]  norm;
		sgn = value_in[15];
		ex  = value_in[14:10];
		m   = value_in[9:0];
		p   = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) begin
				p = 4'(i);
			end
		end
		norm = m << (4'd10 - p);
		if (ex == 5'd0) begin
			if (m == 10'd0) begin
				wide_res = {sgn, 31'd0};
			end else begin
				wide_res = {sgn, 8'({4'd0, p} + 8'd103), norm, 13'd0};
			end
		end else if (ex == 5'h1F) begin
			wide_res = (m != 10'd0) ? F32_QNAN : ({sgn, 31'd0} | F32_INF);
		end else begin
			wide_res = {sgn, 8'({3'd0, ex} + EXP_BIAS_DIFF), m, 13'd0};
		end
	end

	always_comb begin
		case (action)
			ACT_F32_TO_BF16: value_out = {16'd0, bf16_res};
			ACT_F32_TO_FP16: value_out = {16'd0, fp16_res};
			ACT_BF16_TO_F32: value_out = {value_in[15:0], 16'd0};
			ACT_FP16_TO_F32: value_out = wide_res;
			default:         value_out = wide_res;
		endcase
	end

endmodule

// ===== design/float_precision_converter.sv =====
// top level of the fp32 / bf16 / fp16 precision converter
// Converts one word per cycle between fp32 and bf16 or fp16 as chosen by action.
// A word is held in an input register, converted by a single combinational pass
// and captured in the output register when it can take it; a new word is
// taken every cycle while out_stall is low. The output register lets a new word
// enter while a result waits; in_stall rises only when both registers hold words
// and out_stall is high.
module float_precision_converter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fpc_pkg::action_t    action,
	input  logic [31:0]         value_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         value_out
);
	import fpc_pkg::*;

	`include "assert_macros.svh"

	logic        v_s1;
	action_t     act_s1;
	logic [31:0] val_s1;
	logic [31:0] result;
	logic        en_s2;
	logic        en_s1;

	assign en_s2    = !out_valid || !out_stall;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			act_s1 <= action;
			val_s1 <= value_in;
		end
	end

	fpc_convert u_convert (
		.action    (act_s1),
		.value_in  (val_s1),
		.value_out (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_s2) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			value_out <= result;
		end
	end

	// accepted word lands in the input register
	`FPC_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, v_s1,
		"accepted word missing from input register")
	// a converted word moves into the output register
	`FPC_ASSERT_NEXT(a_s1_moves_out, v_s1 && en_s2, out_valid,
		"converted word lost before output register")
	// backpressure only when the whole path is full
	`FPC_ASSERT_NOW(a_stall_only_full, in_stall, v_s1 && out_valid && out_stall,
		"input stalled while the path has room")
	// narrowing results keep the upper half clear
	`FPC_ASSERT_NOW(a_narrow_upper_zero,
		v_s1 && (act_s1 == ACT_F32_TO_BF16 || act_s1 == ACT_F32_TO_FP16),
		result[31:16] == 16'd0,
		"narrowed word has nonzero upper half")

endmodule
